FILE: rtl/stove_on_current_alarm_assert.svh
// ----------------------------------------------------------------------------
// Stove alarm assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STOVE_ON_CURRENT_ALARM_ASSERT_SVH
`define STOVE_ON_CURRENT_ALARM_ASSERT_SVH

// Same-cycle implication.
`define SOC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SOC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/soc_pkg.sv
// ----------------------------------------------------------------------------
// Stove alarm package
// Sizes, register indexes, mode codes, item types and shared helpers.
// ----------------------------------------------------------------------------
package soc_pkg;

  // Sizing.
  localparam int HISTORY_BYTES = 1024;
  localparam int TICKS         = 16;
  localparam int SAMPLE_BITS   = 10;

  localparam int HIST_BITS = HISTORY_BYTES * 8;
  localparam int HB_W      = $clog2(HIST_BITS);
  localparam int BA_W      = $clog2(HISTORY_BYTES);
  localparam int CNT_W     = $clog2(TICKS);
  localparam int ACC_W     = SAMPLE_BITS + CNT_W;
  localparam int DIV_W     = (HB_W + 1 > ACC_W) ? HB_W + 1 : ACC_W;
  localparam int DUTY_W    = 7;
  localparam int DVS_W     = (CNT_W > DUTY_W) ? CNT_W : DUTY_W;
  localparam int DUTY_MAX  = 100;

  // Configuration register widths and port.
  localparam int THR_W  = 10;
  localparam int HCL_W  = 13;
  localparam int BEEP_W = 8;
  localparam int REST_W = 16;
  localparam int QS_W   = 13;
  localparam int ONS_W  = 13;
  localparam int CFG_DW = 16;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] REG_LEVEL_THR  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_DUTY       = 3'd1;
  localparam logic [CFG_IW-1:0] REG_HALF_CYCLE = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BEEP_COUNT = 3'd3;
  localparam logic [CFG_IW-1:0] REG_REST_SECS  = 3'd4;
  localparam logic [CFG_IW-1:0] REG_QUIET_SECS = 3'd5;
  localparam logic [CFG_IW-1:0] REG_ONSET_SECS = 3'd6;

  // Alarm modes and the extra status code.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_ALARM   = 2'd1;
  localparam logic [1:0] MODE_REST    = 2'd2;
  localparam logic [1:0] STAT_ON_IDLE = 2'd3;

  // Reciprocal of three for the two-thirds threshold.
  localparam int K3     = SAMPLE_BITS + 3;
  localparam int RECIP3 = (2 ** K3 + 2) / 3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic                   button_level;
    logic                   second_done;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             alarm_status;
    logic                   beep_drive;
    logic [SAMPLE_BITS-1:0] second_level;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic            we;
    logic [BA_W-1:0] waddr;
    logic [7:0]      wdata;
    logic [BA_W-1:0] raddr;
  } hist_req_t;

  // Two thirds of the peak, truncated, by multiplying with a reciprocal.
  function automatic logic [SAMPLE_BITS-1:0] two_thirds(input logic [SAMPLE_BITS-1:0] peak);
    logic [SAMPLE_BITS:0]            x;
    logic [K3-1:0]                   m;
    logic [SAMPLE_BITS+1+K3-1:0]     prod;
    x    = {peak, 1'b0};
    m    = K3'(RECIP3);
    prod = (SAMPLE_BITS + 1 + K3)'(x) * (SAMPLE_BITS + 1 + K3)'(m);
    return prod[K3 +: SAMPLE_BITS];
  endfunction

endpackage

FILE: rtl/soc_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Restoring divider, one quotient bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module soc_div import soc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic             ge;

  // One restoring step on the current remainder.
  assign shifted = {rem_r, q_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      q_r    <= req.dividend;
      dvs_r  <= req.divisor;
      rem_r  <= '0;
      cnt_r  <= CW'(DIV_W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r  <= ge ? DVS_W'(shifted - {1'b0, dvs_r}) : shifted[DVS_W-1:0];
      q_r    <= {q_r[DIV_W-2:0], ge};
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CW'(1));
      done_r <= (cnt_r == CW'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = q_r;

endmodule

FILE: rtl/soc_hist_ram.sv
// ----------------------------------------------------------------------------
// History memory
// Byte-wide ring of on/off seconds, one write and one registered read port.
// ----------------------------------------------------------------------------
module soc_hist_ram import soc_pkg::*; (
  input  logic      clk,
  input  hist_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] mem_r [HISTORY_BYTES];
  logic [7:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/stove_on_current_alarm.sv
// ----------------------------------------------------------------------------
// Stove-on current alarm
// Per-second current level, one-bit-per-second history ring and alarm machine.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in_       input      in_valid / in_stall   in_item_t  (sample, button, second)
//  out_      output     out_valid / out_stall out_item_t (status, beep, level)
//  cfg_      input      cfg_wr_en             cfg_index, cfg_wdata
//
// A tick without end of second goes through S_POST and S_DONE to the result.
// An end-of-second tick also runs the averaging, the duty-limit divisions and
// a bit-serial scan of the history memory, one bit a cycle.
// A button press adds a clearing pass over every byte of the memory.
// After reset the same clearing pass runs before in_stall drops.
// in_stall is high whenever an item is in work; a stalled result waits in the
// output register while the next item is accepted.
module stove_on_current_alarm import soc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

`include "stove_on_current_alarm_assert.svh"

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LIM    = 4'd2;
  localparam logic [3:0] S_AVG    = 4'd3;
  localparam logic [3:0] S_AVGD   = 4'd4;
  localparam logic [3:0] S_RMW_RD = 4'd5;
  localparam logic [3:0] S_RMW_WR = 4'd6;
  localparam logic [3:0] S_HCLR   = 4'd7;
  localparam logic [3:0] S_DIV1   = 4'd8;
  localparam logic [3:0] S_DIV2   = 4'd9;
  localparam logic [3:0] S_SCAN0  = 4'd10;
  localparam logic [3:0] S_SCAN   = 4'd11;
  localparam logic [3:0] S_JUDGE  = 4'd12;
  localparam logic [3:0] S_POST   = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  // Configuration registers.
  logic [THR_W-1:0]  level_thr_r;
  logic [DUTY_W-1:0] duty_r;
  logic [HCL_W-1:0]  half_cycle_r;
  logic [BEEP_W-1:0] beep_count_r;
  logic [REST_W-1:0] rest_secs_r;
  logic [QS_W-1:0]   quiet_secs_r;
  logic [ONS_W-1:0]  onset_secs_r;

  // Sequencer and datapath state.
  logic [3:0]             state_r, state_nxt;
  logic [BA_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic                   out_pend_r, out_pend_nxt;
  logic [SAMPLE_BITS-1:0] store_r [TICKS];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [SAMPLE_BITS-1:0] peak_r, peak_nxt;
  logic                   btn_r, btn_nxt;
  logic                   button_last_r, button_last_nxt;
  logic [SAMPLE_BITS-1:0] lim_r, lim_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [HB_W-1:0]        head_r, head_nxt;
  logic                   dvalid_r, dvalid_nxt;
  logic [DIV_W-1:0]       dlim_r, dlim_nxt;
  logic [HB_W-1:0]        p_r, p_nxt;
  logic [HB_W-1:0]        i_r, i_nxt;
  logic [HB_W-1:0]        total_r, total_nxt;
  logic [HB_W-1:0]        trans_r, trans_nxt;
  logic [HB_W-1:0]        quiet_r, quiet_nxt;
  logic                   prev_r, prev_nxt;
  logic                   found_r, found_nxt;
  logic [HB_W-1:0]        first_r, first_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic [REST_W-1:0]      timer_r, timer_nxt;
  logic                   beep_r, beep_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  // Helpers.
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  hist_req_t         ram_req;
  logic [7:0]        ram_rdata;
  logic              hbit;
  logic [HB_W-1:0]   p_inc;
  logic [HB_W:0]     p_start;
  logic [HB_W-1:0]   quiet_inc;
  logic [HB_W-1:0]   head_inc;
  logic              lvl_on;
  logic              busy;
  logic              ev;
  logic [REST_W-1:0] timer_inc;

  soc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  soc_hist_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_thr_r  <= THR_W'(512);
      duty_r       <= DUTY_W'(25);
      half_cycle_r <= HCL_W'(100);
      beep_count_r <= BEEP_W'(10);
      rest_secs_r  <= REST_W'(300);
      quiet_secs_r <= QS_W'(1800);
      onset_secs_r <= ONS_W'(5400);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LEVEL_THR:  level_thr_r  <= cfg_wdata[THR_W-1:0];
        REG_DUTY:       duty_r       <= cfg_wdata[DUTY_W-1:0];
        REG_HALF_CYCLE: half_cycle_r <= cfg_wdata[HCL_W-1:0];
        REG_BEEP_COUNT: beep_count_r <= cfg_wdata[BEEP_W-1:0];
        REG_REST_SECS:  rest_secs_r  <= cfg_wdata[REST_W-1:0];
        REG_QUIET_SECS: quiet_secs_r <= cfg_wdata[QS_W-1:0];
        REG_ONSET_SECS: onset_secs_r <= cfg_wdata[ONS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample store write on every accepted item.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      store_r[count_r] <= in_data.adc_sample;
    end
  end

  // Shared combinational terms.
  assign lvl_on    = avg_r > level_thr_r;
  assign hbit      = ram_rdata[p_r[2:0]];
  assign p_inc     = (p_r == HB_W'(HIST_BITS - 1)) ? '0 : p_r + 1'b1;
  assign head_inc  = (head_r == HB_W'(HIST_BITS - 1)) ? '0 : head_r + 1'b1;
  assign quiet_inc = quiet_r + 1'b1;
  assign timer_inc = timer_r + 1'b1;
  assign p_start   = ({1'b0, head_r} + (HB_W + 1)'(8) >= (HB_W + 1)'(HIST_BITS))
                   ? {1'b0, head_r} + (HB_W + 1)'(8) - (HB_W + 1)'(HIST_BITS)
                   : {1'b0, head_r} + (HB_W + 1)'(8);

  // Event decision from the finished scan.
  assign busy = (trans_r > half_cycle_r) || (dvalid_r && (DIV_W'(total_r) > dlim_r));
  assign ev   = busy && found_r && lvl_on
             && (((HB_W + 1)'(HIST_BITS) - {1'b0, first_r}) > onset_secs_r);

  // Sequencer.
  always_comb begin
    state_nxt       = state_r;
    clr_addr_nxt    = clr_addr_r;
    out_pend_nxt    = out_pend_r;
    count_nxt       = count_r;
    peak_nxt        = peak_r;
    btn_nxt         = btn_r;
    button_last_nxt = button_last_r;
    lim_nxt         = lim_r;
    idx_nxt         = idx_r;
    acc_nxt         = acc_r;
    n_nxt           = n_r;
    avg_nxt         = avg_r;
    head_nxt        = head_r;
    dvalid_nxt      = dvalid_r;
    dlim_nxt        = dlim_r;
    p_nxt           = p_r;
    i_nxt           = i_r;
    total_nxt       = total_r;
    trans_nxt       = trans_r;
    quiet_nxt       = quiet_r;
    prev_nxt        = prev_r;
    found_nxt       = found_r;
    first_nxt       = first_r;
    mode_nxt        = mode_r;
    timer_nxt       = timer_r;
    beep_nxt        = beep_r;
    status_nxt      = status_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r;
    div_req         = '0;
    ram_req         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // Zero the history one byte a cycle.
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_addr_r;
        ram_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + 1'b1;
        if (clr_addr_r == BA_W'(HISTORY_BYTES - 1)) begin
          clr_addr_nxt = '0;
          out_pend_nxt = 1'b0;
          state_nxt    = out_pend_r ? S_DONE : S_IDLE;
        end
      end
      // Take an item: store the sample and track the peak.
      S_IDLE: begin
        if (in_valid) begin
          count_nxt = (count_r == CNT_W'(TICKS - 1)) ? count_r : count_r + 1'b1;
          if (in_data.adc_sample > peak_r) begin
            peak_nxt = in_data.adc_sample;
          end
          btn_nxt   = in_data.button_level;
          state_nxt = in_data.second_done ? S_LIM : S_POST;
        end
      end
      S_LIM: begin
        lim_nxt   = two_thirds(peak_r);
        peak_nxt  = '0;
        idx_nxt   = '0;
        acc_nxt   = '0;
        n_nxt     = '0;
        state_nxt = S_AVG;
      end
      // Sum the samples above two thirds of the peak, then divide by their number (zero if none).
      S_AVG: begin
        if (idx_r < count_r) begin
          if (store_r[idx_r] > lim_r) begin
            acc_nxt = acc_r + ACC_W'(store_r[idx_r]);
            n_nxt   = n_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end else begin
          count_nxt = '0;
          if (n_r != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(acc_r);
            div_req.divisor  = DVS_W'(n_r);
            state_nxt        = S_AVGD;
          end else begin
            avg_nxt   = '0;
            state_nxt = S_RMW_RD;
          end
        end
      end
      S_AVGD: begin
        if (div_rsp.done) begin
          avg_nxt   = div_rsp.quo[SAMPLE_BITS-1:0];
          state_nxt = S_RMW_RD;
        end
      end
      // Record this second's bit.
      S_RMW_RD: begin
        ram_req.raddr = head_r[HB_W-1:3];
        state_nxt     = S_RMW_WR;
      end
      S_RMW_WR: begin
        ram_req.we    = lvl_on;
        ram_req.waddr = head_r[HB_W-1:3];
        ram_req.wdata = ram_rdata | (8'd1 << head_r[2:0]);
        head_nxt      = head_inc;
        state_nxt     = S_HCLR;
      end
      // Clear the byte the head enters, then derive the duty limit.
      S_HCLR: begin
        ram_req.we    = (head_r[2:0] == 3'd0);
        ram_req.waddr = head_r[HB_W-1:3];
        ram_req.wdata = '0;
        if (duty_r != '0 && duty_r <= DUTY_W'(DUTY_MAX)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(DUTY_MAX);
          div_req.divisor  = DVS_W'(duty_r);
          state_nxt        = S_DIV1;
        end else begin
          dvalid_nxt = 1'b0;
          state_nxt  = S_SCAN0;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(HIST_BITS);
          div_req.divisor  = div_rsp.quo[DVS_W-1:0];
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          dlim_nxt   = div_rsp.quo;
          dvalid_nxt = 1'b1;
          state_nxt  = S_SCAN0;
        end
      end
      // Start the scan just past the cleared byte.
      S_SCAN0: begin
        p_nxt         = p_start[HB_W-1:0];
        ram_req.raddr = p_start[HB_W-1:3];
        i_nxt         = HB_W'(8);
        total_nxt     = '0;
        trans_nxt     = '0;
        quiet_nxt     = '0;
        prev_nxt      = 1'b0;
        found_nxt     = 1'b0;
        first_nxt     = '0;
        state_nxt     = S_SCAN;
      end
      // One history bit a cycle, oldest to newest.
      S_SCAN: begin
        total_nxt = total_r + HB_W'(hbit);
        if (hbit != prev_r) begin
          trans_nxt = trans_r + 1'b1;
          prev_nxt  = hbit;
        end
        if (hbit) begin
          quiet_nxt = '0;
        end else begin
          quiet_nxt = quiet_inc;
          if (quiet_inc >= quiet_secs_r) begin
            total_nxt = '0;
            trans_nxt = '0;
          end
        end
        if (hbit && !found_r) begin
          found_nxt = 1'b1;
          first_nxt = i_r;
        end
        p_nxt         = p_inc;
        ram_req.raddr = p_inc[HB_W-1:3];
        i_nxt         = i_r + 1'b1;
        if (i_r == HB_W'(HIST_BITS - 1)) begin
          state_nxt = S_JUDGE;
        end
      end
      // Step the alarm machine.
      S_JUDGE: begin
        case (mode_r)
          MODE_ALARM: begin
            timer_nxt = timer_inc;
            if (timer_inc[0]) begin
              beep_nxt = 1'b1;
            end else begin
              beep_nxt = 1'b0;
              if (timer_inc >= REST_W'({beep_count_r, 1'b0})) begin
                mode_nxt  = MODE_REST;
                timer_nxt = '0;
              end
            end
          end
          MODE_REST: begin
            timer_nxt = timer_inc;
            if (timer_inc >= rest_secs_r) begin
              mode_nxt  = ev ? MODE_ALARM : MODE_IDLE;
              timer_nxt = '0;
            end
          end
          default: begin
            if (ev) begin
              mode_nxt  = MODE_ALARM;
              timer_nxt = '0;
            end
          end
        endcase
        state_nxt = S_POST;
      end
      // Button edge: a press clears the history and the alarm.
      S_POST: begin
        if (state_r == S_POST) begin
          status_nxt = status_r;
        end
        state_nxt = S_DONE;
        if (btn_r != button_last_r) begin
          button_last_nxt = btn_r;
          if (!btn_r) begin
            mode_nxt     = MODE_IDLE;
            out_pend_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end
        end
      end
      // Hand the result to the output register.
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.alarm_status = status_r;
          out_nxt.beep_drive   = beep_r;
          out_nxt.second_level = avg_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Shown status follows the alarm machine at the end of a second.
    if (state_r == S_JUDGE) begin
      status_nxt = (mode_nxt == MODE_IDLE && lvl_on) ? STAT_ON_IDLE : mode_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_addr_r    <= '0;
      out_pend_r    <= 1'b0;
      count_r       <= '0;
      peak_r        <= '0;
      button_last_r <= 1'b0;
      avg_r         <= '0;
      head_r        <= '0;
      mode_r        <= MODE_IDLE;
      timer_r       <= '0;
      beep_r        <= 1'b0;
      status_r      <= MODE_IDLE;
      out_valid_r   <= 1'b0;
      dvalid_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      out_pend_r    <= out_pend_nxt;
      count_r       <= count_nxt;
      peak_r        <= peak_nxt;
      button_last_r <= button_last_nxt;
      avg_r         <= avg_nxt;
      head_r        <= head_nxt;
      mode_r        <= mode_nxt;
      timer_r       <= timer_nxt;
      beep_r        <= beep_nxt;
      status_r      <= status_nxt;
      out_valid_r   <= out_valid_nxt;
      dvalid_r      <= dvalid_nxt;
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    btn_r   <= btn_nxt;
    lim_r   <= lim_nxt;
    idx_r   <= idx_nxt;
    acc_r   <= acc_nxt;
    n_r     <= n_nxt;
    dlim_r  <= dlim_nxt;
    p_r     <= p_nxt;
    i_r     <= i_nxt;
    total_r <= total_nxt;
    trans_r <= trans_nxt;
    quiet_r <= quiet_nxt;
    prev_r  <= prev_nxt;
    found_r <= found_nxt;
    first_r <= first_nxt;
    out_r   <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The divider only reports while the sequencer waits for it.
  `SOC_ASSERT_IMP(a_div_done_wait, div_rsp.done,
    (state_r == S_AVGD) || (state_r == S_DIV1) || (state_r == S_DIV2),
    "divider result outside a wait state")

  // The history is never written during the scan.
  `SOC_ASSERT_IMP(a_no_write_in_scan, (state_r == S_SCAN) || (state_r == S_JUDGE),
    !ram_req.we, "history write during scan")

  // A result held by the consumer is not overwritten.
  `SOC_ASSERT_NXT(a_done_holds, (state_r == S_DONE) && out_valid_r && out_stall,
    (state_r == S_DONE) && out_valid_r, "pending result overwritten")

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// Stove-on current alarm testbench
// Drives ticks through the valid/stall input channel, takes expected results
// from directed rows or a behavioral copy of the sampling, history ring and
// alarm machine, checks the result channel field by field, and uses several
// register settings, the extremes too, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import soc_pkg::*;
();

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_wr_en;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  stove_on_current_alarm uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Directed stimulus row; exp is used only where chk is set.
  typedef struct {
    in_item_t  item;
    int        reps;
    bit        chk;
    out_item_t exp;
  } plan_row_t;

  out_item_t pending_results[$];
  int        mismatches;
  bit        calm;

  // Behavioral copy of the block state and registers.
  int        thr_reg, duty_reg, hcl_reg, beep_reg, rest_reg, quiet_reg, onset_reg;
  int        tick_samples[TICKS];
  int        tick_count, tick_peak, sec_level;
  bit        on_ring[HIST_BITS];
  int        ring_head, mode_timer;
  logic [1:0] alarm_mode, shown_status;
  bit        beep_on, button_prev;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #48000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver stall, random except during calm stretches.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 34);
    end
  end

  // Result check; outputs are stable between edges, so sample at negedge.
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result item: status %0d beep %0d level %0d",
                   out_data.alarm_status, out_data.beep_drive, out_data.second_level);
        end
      end else begin
        want = pending_results.pop_front();
        if (want.alarm_status !== out_data.alarm_status ||
            want.beep_drive !== out_data.beep_drive ||
            want.second_level !== out_data.second_level) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected status %0d beep %0d level %0d, got %0d %0d %0d",
                     want.alarm_status, want.beep_drive, want.second_level,
                     out_data.alarm_status, out_data.beep_drive, out_data.second_level);
          end
        end
      end
    end
  end

  // Predictor register update.
  function automatic void set_reg(logic [CFG_IW-1:0] idx, int val);
    case (idx)
      REG_LEVEL_THR:  thr_reg   = val & 'h3FF;
      REG_DUTY:       duty_reg  = val & 'h7F;
      REG_HALF_CYCLE: hcl_reg   = val & 'h1FFF;
      REG_BEEP_COUNT: beep_reg  = val & 'hFF;
      REG_REST_SECS:  rest_reg  = val & 'hFFFF;
      REG_QUIET_SECS: quiet_reg = val & 'h1FFF;
      REG_ONSET_SECS: onset_reg = val & 'h1FFF;
      default: ;
    endcase
  endfunction

  // Scan the ring from oldest to newest and decide whether to alarm.
  function automatic bit stove_left_on();
    int  pos, on_total, flips, off_run, first_on;
    bit  prev, b, busy;
    pos = ring_head + 8;
    if (pos >= HIST_BITS) pos -= HIST_BITS;
    prev = 1'b0;
    on_total = 0;
    flips = 0;
    off_run = 0;
    first_on = HIST_BITS;
    for (int i = 8; i < HIST_BITS; i++) begin
      b = on_ring[pos];
      on_total += b;
      if (b != prev) begin
        flips++;
        prev = b;
      end
      if (b) begin
        off_run = 0;
      end else begin
        off_run++;
        if (off_run >= quiet_reg) begin
          on_total = 0;
          flips = 0;
        end
      end
      if (b && first_on == HIST_BITS) first_on = i;
      pos++;
      if (pos >= HIST_BITS) pos = 0;
    end
    busy = (flips > hcl_reg);
    if (duty_reg >= 1 && duty_reg <= DUTY_MAX) begin
      if (on_total > HIST_BITS / (DUTY_MAX / duty_reg)) busy = 1'b1;
    end
    return busy && (HIST_BITS - first_on > onset_reg) && (sec_level > thr_reg);
  endfunction

  // Per-second average, history update and alarm machine step.
  function automatic void close_second();
    int sum, n, lim;
    bit fire;
    sum = 0;
    n = 0;
    lim = tick_peak * 2 / 3;
    for (int i = 0; i < tick_count; i++) begin
      if (tick_samples[i] > lim) begin
        sum += tick_samples[i];
        n++;
      end
    end
    sec_level = (n != 0) ? sum / n : 0;
    tick_peak = 0;
    tick_count = 0;
    if (sec_level > thr_reg) on_ring[ring_head] = 1'b1;
    ring_head++;
    if (ring_head >= HIST_BITS) ring_head = 0;
    if ((ring_head & 7) == 0) begin
      for (int k = 0; k < 8; k++) on_ring[ring_head + k] = 1'b0;
    end
    fire = stove_left_on();
    case (alarm_mode)
      MODE_ALARM: begin
        mode_timer = (mode_timer + 1) & 'hFFFF;
        if (mode_timer & 1) begin
          beep_on = 1'b1;
        end else begin
          beep_on = 1'b0;
          if (mode_timer >= beep_reg * 2) begin
            alarm_mode = MODE_REST;
            mode_timer = 0;
          end
        end
      end
      MODE_REST: begin
        mode_timer = (mode_timer + 1) & 'hFFFF;
        if (mode_timer >= rest_reg) begin
          alarm_mode = fire ? MODE_ALARM : MODE_IDLE;
          mode_timer = 0;
        end
      end
      default: begin
        if (fire) begin
          alarm_mode = MODE_ALARM;
          mode_timer = 0;
        end
      end
    endcase
    if (alarm_mode == MODE_IDLE && sec_level > thr_reg) shown_status = STAT_ON_IDLE;
    else shown_status = alarm_mode;
  endfunction

  // Work out the result of one accepted tick.
  function automatic out_item_t alarm_predict(in_item_t it);
    out_item_t r;
    if (tick_count >= TICKS) tick_count = TICKS - 1;
    tick_samples[tick_count] = it.adc_sample;
    tick_count++;
    if (tick_count >= TICKS) tick_count = TICKS - 1;
    if (it.adc_sample > tick_peak) tick_peak = it.adc_sample;
    if (it.second_done) close_second();
    if (button_prev != it.button_level) begin
      if (!it.button_level) begin
        for (int k = 0; k < HIST_BITS; k++) on_ring[k] = 1'b0;
        alarm_mode = MODE_IDLE;
      end
      button_prev = it.button_level;
    end
    r.alarm_status = shown_status;
    r.beep_drive   = beep_on;
    r.second_level = sec_level[SAMPLE_BITS-1:0];
    return r;
  endfunction

  // Offer one tick and wait until it is taken.
  task automatic send_tick(in_item_t it, bit typed, out_item_t typed_exp);
    out_item_t p;
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    p = alarm_predict(it);
    pending_results.push_back(typed ? typed_exp : p);
    @(posedge clk);
  endtask

  // Wait for every result, then let the block settle before a register write.
  task automatic drain();
    @(posedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_regs(int thr, int duty, int hcl, int beeps, int rest, int quiet,
                            int onset);
    int vals[7];
    vals = '{thr, duty, hcl, beeps, rest, quiet, onset};
    for (int i = 0; i < 7; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IW'(i);
      cfg_wdata <= CFG_DW'(vals[i]);
      set_reg(CFG_IW'(i), vals[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random seconds of random length, with button presses and stray flags.
  task automatic random_ticks(int count);
    int        sent, len, press_left;
    in_item_t  it;
    out_item_t none;
    sent = 0;
    press_left = 0;
    none = '0;
    while (sent < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 6);
      for (int t = 0; t < len && sent < count; t++) begin
        case ($urandom_range(5))
          0: it.adc_sample = '0;
          1: it.adc_sample = '1;
          2: it.adc_sample = SAMPLE_BITS'($urandom_range(700, 1023));
          default: it.adc_sample = SAMPLE_BITS'($urandom);
        endcase
        if (press_left == 0 && $urandom_range(24) == 0) press_left = $urandom_range(1, 2);
        it.button_level = (press_left == 0);
        if (press_left > 0) press_left--;
        it.second_done = (t == len - 1) || ($urandom_range(14) == 0);
        send_tick(it, 1'b0, none);
        sent++;
        if (sent == 15) calm = 1'b0;
      end
    end
  endtask

  function automatic plan_row_t mk_row(int smp, bit btn, bit sec, int reps, bit chk,
                                       logic [1:0] st, bit bp, int lvl);
    plan_row_t r;
    r.item.adc_sample   = SAMPLE_BITS'(smp);
    r.item.button_level = btn;
    r.item.second_done  = sec;
    r.reps              = reps;
    r.chk               = chk;
    r.exp.alarm_status  = st;
    r.exp.beep_drive    = bp;
    r.exp.second_level  = SAMPLE_BITS'(lvl);
    return r;
  endfunction

  // Main sequence.
  initial begin
    plan_row_t plan[13];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm      = 1'b1;
    mismatches = 0;
    thr_reg = 512; duty_reg = 25; hcl_reg = 100; beep_reg = 10;
    rest_reg = 300; quiet_reg = 1800; onset_reg = 5400;
    tick_count = 0; tick_peak = 0; sec_level = 0; ring_head = 0; mode_timer = 0;
    alarm_mode = MODE_IDLE; shown_status = MODE_IDLE; beep_on = 1'b0; button_prev = 1'b0;
    foreach (on_ring[k]) on_ring[k] = 1'b0;
    foreach (tick_samples[k]) tick_samples[k] = 0;

    // After reset, extremes, empty average, full buffer, button presses,
    // and the threshold boundary.
    plan[0]  = mk_row(0,    1, 0, 1,  1, MODE_IDLE,    0, 0);
    plan[1]  = mk_row(1023, 1, 0, 1,  1, MODE_IDLE,    0, 0);
    plan[2]  = mk_row(1023, 1, 1, 1,  1, STAT_ON_IDLE, 0, 1023);
    plan[3]  = mk_row(0,    1, 1, 1,  1, MODE_IDLE,    0, 0);
    plan[4]  = mk_row(600,  1, 0, 18, 0, MODE_IDLE,    0, 0);
    plan[5]  = mk_row(900,  1, 1, 1,  0, MODE_IDLE,    0, 0);
    plan[6]  = mk_row(0,    0, 0, 1,  0, MODE_IDLE,    0, 0);
    plan[7]  = mk_row(0,    0, 1, 1,  0, MODE_IDLE,    0, 0);
    plan[8]  = mk_row(1,    1, 0, 1,  0, MODE_IDLE,    0, 0);
    plan[9]  = mk_row(1023, 0, 1, 1,  0, MODE_IDLE,    0, 0);
    plan[10] = mk_row(512,  1, 1, 1,  1, MODE_IDLE,    0, 512);
    plan[11] = mk_row(513,  1, 1, 1,  1, STAT_ON_IDLE, 0, 513);
    plan[12] = mk_row(341,  1, 0, 1,  0, MODE_IDLE,    0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    drain();

    foreach (plan[r]) begin
      for (int k = 0; k < plan[r].reps; k++) send_tick(plan[r].item, plan[r].chk, plan[r].exp);
    end
    drain();

    // Alarm on the first on second, shortest burst and rest.
    write_regs(0, 100, 0, 1, 1, 1, 0);
    random_ticks(30);
    drain();

    // Largest values: nothing can count as on.
    write_regs(1023, 127, 8191, 255, 65535, 8191, 8191);
    random_ticks(10);
    drain();

    // Middle settings with short quiet runs.
    write_regs(300, 1, 2, 3, 4, 5, 2);
    random_ticks(30);
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/soc_pkg.sv
rtl/soc_div.sv
rtl/soc_hist_ram.sv
rtl/stove_on_current_alarm.sv
test/testbench.sv
